// ----- design/pdcd_pkg.sv -----
// Shared types and codes of the palette delta chunk decoder.
// Used by pdcd_ctrl, pdcd_dpath and the top level; depends on nothing.
package pdcd_pkg;

    // result status codes
    localparam logic [2:0] ST_ACCEPTED      = 3'd0;
    localparam logic [2:0] ST_COMPLETE      = 3'd1;
    localparam logic [2:0] ST_COMPLETE_OVER = 3'd2;
    localparam logic [2:0] ST_IGNORED       = 3'd3;
    localparam logic [2:0] ST_READ          = 3'd4;

    // what the request at the input asks of the controller
    typedef enum logic [1:0] {
        K_SIMPLE  = 2'd0,
        K_RUN     = 2'd1,
        K_LITERAL = 2'd2
    } t_kind;

    typedef struct packed {
        logic clr;
        logic accept;
        logic run_step;
        logic fin;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic  clr_done;
        logic  run_last;
        t_kind kind;
        logic  out_busy;
    } t_sts;

endpackage

// ----- design/palette_delta_chunk_decoder_core.sv -----
// Top level of the palette delta chunk decoder: controller plus datapath.
// Depends on pdcd_pkg, pdcd_ctrl and pdcd_dpath.
//
// Decodes palette update chunks one body byte per request into a new palette of
// PALETTE_ENTRIES RGB entries, built from the live one, and answers read requests
// with one live entry scaled by four (modulo 256). Every request yields exactly one
// result. Steps per request: a read or a byte that only parses goes from accept
// to result; the blue byte of a literal adds a finish step; a keep or copy byte
// adds a copy step per entry of its run before the finish, since the copy runs
// through the single read port of the palette memory at one entry per cycle. A
// result sits in an output register, so the next request is taken while it waits;
// a stalled output holds back only a second result that is ready. After reset
// the block runs a clearing pass over all 2*PALETTE_ENTRIES entries of both
// palette banks, with the input stalled, before it takes its first request.
module palette_delta_chunk_decoder_core #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // request channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_req_type,
    input  logic       i_chunk_start,
    input  logic [7:0] i_data_byte,
    input  logic [7:0] i_read_index,
    // result channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_status,
    output logic [7:0] o_red_out,
    output logic [7:0] o_green_out,
    output logic [7:0] o_blue_out
);
    import pdcd_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequence clear, accept, copy run, finish and push
    pdcd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // hold parser state, palette banks and the result register
    pdcd_dpath #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_req_type    (i_req_type),
        .i_chunk_start (i_chunk_start),
        .i_data_byte   (i_data_byte),
        .i_read_index  (i_read_index),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_red_out     (o_red_out),
        .o_green_out   (o_green_out),
        .o_blue_out    (o_blue_out)
    );

endmodule

// ----- design/pdcd_ctrl.sv -----
// Controller state machine of the palette delta chunk decoder.
// Depends on pdcd_pkg; drives commands to pdcd_dpath from its status.
module pdcd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  pdcd_pkg::t_sts i_sts,
    output pdcd_pkg::t_cmd o_cmd
);
    import pdcd_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_RUN   = 5'b00100,
        S_FIN   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    case (i_sts.kind)
                        K_RUN:     n_state = S_RUN;
                        K_LITERAL: n_state = S_FIN;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_RUN: begin
                o_cmd.run_step = 1'b1;
                if (i_sts.run_last) n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                // hold the result until the output register frees up
                if (!i_sts.out_busy) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state != S_IDLE))
        else $error("controller stayed idle after taking a request");

    a_fin_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> ($past(r_state) == S_RUN || $past(r_state) == S_IDLE))
        else $error("finish step entered from an unexpected state");

endmodule

// ----- design/pdcd_dpath.sv -----
// Datapath of the palette delta chunk decoder: parser registers, the
// two-bank palette memory, the copy pipeline and the output register.
// Depends on pdcd_pkg; steered by commands from pdcd_ctrl.
module pdcd_dpath #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pdcd_pkg::t_cmd i_cmd,
    output pdcd_pkg::t_sts o_sts,
    input  logic           i_req_type,
    input  logic           i_chunk_start,
    input  logic [7:0]     i_data_byte,
    input  logic [7:0]     i_read_index,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [2:0]     o_status,
    output logic [7:0]     o_red_out,
    output logic [7:0]     o_green_out,
    output logic [7:0]     o_blue_out
);
    import pdcd_pkg::*;

    localparam int DEPTH = 2 * PALETTE_ENTRIES;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(PALETTE_ENTRIES + 1);
    localparam logic [8:0]    NV       = 9'(PALETTE_ENTRIES);
    localparam logic [IW-1:0] NI       = IW'(PALETTE_ENTRIES);
    localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_CMD   = 5'b00010,
        PH_INDEX = 5'b00100,
        PH_GREEN = 5'b01000,
        PH_BLUE  = 5'b10000
    } t_phase;

    function automatic logic [AW-1:0] f_addr(input logic bank, input logic [IW-1:0] idx);
        f_addr = bank ? (AW'(PALETTE_ENTRIES) + AW'(idx)) : AW'(idx);
    endfunction

    logic [23:0]   r_mem [DEPTH];
    logic [23:0]   r_rdata;

    t_phase        r_phase, n_phase;
    logic          r_bank, n_bank;
    logic [IW-1:0] r_build_idx, n_build_idx;
    logic [5:0]    r_pending, n_pending;
    logic [7:0]    r_red, n_red;
    logic [7:0]    r_green, n_green;
    logic [7:0]    r_left, n_left;
    logic [7:0]    r_src, n_src;
    logic          r_keep, n_keep;
    logic          r_over, n_over;
    logic          r_wr_vld, n_wr_vld;
    logic [IW-1:0] r_wr_dst, n_wr_dst;
    logic          r_wr_zero, n_wr_zero;
    logic [2:0]    r_status, n_status;
    logic          r_zero, n_zero;
    logic [AW-1:0] r_clr_addr;
    logic          r_out_valid;
    logic [2:0]    r_out_status;
    logic [7:0]    r_out_red, r_out_green, r_out_blue;

    t_phase        ph_eff;
    logic [IW-1:0] bi_eff;
    t_kind         kind;
    logic          src_zero;
    logic          ridx_zero;
    logic          hit_end;
    logic          run_last;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          we;
    logic [AW-1:0] wa;
    logic [23:0]   wd;

    // a chunk start restarts the build and parses the byte as a command
    assign ph_eff    = i_chunk_start ? PH_CMD : r_phase;
    assign bi_eff    = i_chunk_start ? '0 : r_build_idx;
    assign ridx_zero = ({1'b0, i_read_index} >= NV);
    assign src_zero  = !r_keep && ({1'b0, r_src} >= NV);
    assign hit_end   = (IW'(r_build_idx + 1'b1) == NI);
    assign run_last  = (r_left == 8'd1) || hit_end;

    always_comb begin
        kind = K_SIMPLE;
        if (!i_req_type) begin
            case (ph_eff)
                PH_CMD:   kind = i_data_byte[7] ? K_RUN : K_SIMPLE;
                PH_INDEX: kind = K_RUN;
                PH_BLUE:  kind = K_LITERAL;
                default:  kind = K_SIMPLE;
            endcase
        end
    end

    assign o_sts.clr_done = (r_clr_addr == CLR_LAST);
    assign o_sts.run_last = run_last;
    assign o_sts.kind     = kind;
    assign o_sts.out_busy = r_out_valid && i_stall;

    always_comb begin
        n_phase     = r_phase;
        n_bank      = r_bank;
        n_build_idx = r_build_idx;
        n_pending   = r_pending;
        n_red       = r_red;
        n_green     = r_green;
        n_left      = r_left;
        n_src       = r_src;
        n_keep      = r_keep;
        n_over      = r_over;
        n_wr_vld    = 1'b0;
        n_wr_dst    = r_wr_dst;
        n_wr_zero   = r_wr_zero;
        n_status    = r_status;
        n_zero      = r_zero;

        if (i_cmd.accept) begin
            n_over = 1'b0;
            if (i_req_type) begin
                n_status = ST_READ;
                n_zero   = ridx_zero;
            end else begin
                n_status    = ST_ACCEPTED;
                n_zero      = 1'b1;
                n_phase     = ph_eff;
                n_build_idx = bi_eff;
                case (ph_eff)
                    PH_CMD: begin
                        if (i_data_byte[7]) begin
                            n_keep = 1'b1;
                            n_left = 8'(i_data_byte[6:0]) + 8'd1;
                        end else if (i_data_byte[6]) begin
                            n_pending = i_data_byte[5:0];
                            n_phase   = PH_INDEX;
                        end else begin
                            n_red   = i_data_byte;
                            n_phase = PH_GREEN;
                        end
                    end
                    PH_INDEX: begin
                        n_keep  = 1'b0;
                        n_src   = i_data_byte;
                        n_left  = 8'(r_pending) + 8'd1;
                        n_phase = PH_CMD;
                    end
                    PH_GREEN: begin
                        n_green = i_data_byte;
                        n_phase = PH_BLUE;
                    end
                    PH_BLUE: begin
                        n_build_idx = IW'(bi_eff + 1'b1);
                        n_phase     = PH_CMD;
                    end
                    default: begin
                        n_phase  = PH_IDLE;
                        n_status = ST_IGNORED;
                    end
                endcase
            end
        end

        // issue one copy read per cycle; the write lands in the cycle after its read
        if (i_cmd.run_step) begin
            n_build_idx = IW'(r_build_idx + 1'b1);
            n_left      = r_left - 8'd1;
            n_src       = r_src + 8'd1;
            n_wr_vld    = 1'b1;
            n_wr_dst    = r_build_idx;
            n_wr_zero   = src_zero;
            if (run_last) n_over = hit_end && (r_left != 8'd1);
        end

        if (i_cmd.fin) begin
            if (r_build_idx == NI) begin
                n_bank      = ~r_bank;
                n_phase     = PH_IDLE;
                n_build_idx = '0;
                n_status    = r_over ? ST_COMPLETE_OVER : ST_COMPLETE;
            end
        end
    end

    // read port: live bank only
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = f_addr(r_bank, r_keep ? r_build_idx : IW'(r_src));
        if (i_cmd.accept && i_req_type) begin
            rd_en   = !ridx_zero;
            rd_addr = f_addr(r_bank, IW'(i_read_index));
        end else if (i_cmd.run_step) begin
            rd_en = !src_zero;
        end
    end

    // write port: clearing pass over both banks, or copy pipeline or literal entry into the other bank
    always_comb begin
        we = 1'b0;
        wa = r_clr_addr;
        wd = '0;
        if (i_cmd.clr) begin
            we = 1'b1;
        end else if (r_wr_vld) begin
            we = 1'b1;
            wa = f_addr(~r_bank, r_wr_dst);
            wd = r_wr_zero ? 24'd0 : r_rdata;
        end else if (i_cmd.accept && (kind == K_LITERAL)) begin
            we = 1'b1;
            wa = f_addr(~r_bank, r_build_idx);
            wd = {r_red, r_green, i_data_byte};
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wa] <= wd;
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bank      <= 1'b0;
            r_build_idx <= '0;
            r_pending   <= '0;
            r_red       <= '0;
            r_green     <= '0;
            r_left      <= '0;
            r_over      <= 1'b0;
            r_wr_vld    <= 1'b0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_bank      <= n_bank;
            r_build_idx <= n_build_idx;
            r_pending   <= n_pending;
            r_red       <= n_red;
            r_green     <= n_green;
            r_left      <= n_left;
            r_over      <= n_over;
            r_wr_vld    <= n_wr_vld;
            if (i_cmd.clr) r_clr_addr <= AW'(r_clr_addr + 1'b1);
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_src     <= n_src;
        r_keep    <= n_keep;
        r_wr_dst  <= n_wr_dst;
        r_wr_zero <= n_wr_zero;
        r_status  <= n_status;
        r_zero    <= n_zero;
        if (i_cmd.push) begin
            r_out_status <= r_status;
            r_out_red    <= r_zero ? 8'd0 : {r_rdata[21:16], 2'b00};
            r_out_green  <= r_zero ? 8'd0 : {r_rdata[13:8], 2'b00};
            r_out_blue   <= r_zero ? 8'd0 : {r_rdata[5:0], 2'b00};
        end
    end

    assign o_valid     = r_out_valid;
    assign o_status    = r_out_status;
    assign o_red_out   = r_out_red;
    assign o_green_out = r_out_green;
    assign o_blue_out  = r_out_blue;

    a_build_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_build_idx <= NI)
        else $error("build index ran past the palette size");

    a_write_follows_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_vld |-> $past(i_cmd.run_step))
        else $error("copy write without a preceding copy read");

endmodule
